// ----- design/qvr_pkg.sv -----
`timescale 1ns / 1ps
package qvr_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_W = 2'd0,
		REG_X = 2'd1,
		REG_Y = 2'd2,
		REG_Z = 2'd3
	} reg_idx_t;

	// control that travels with each word down the pipe
	typedef struct packed {
		logic vld;
		logic znorm;
	} qvr_ctl_t;

endpackage

// ----- design/quaternion_vector_rotate_core.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle unless the output word is held; the round-to-nearest divide by the squared
// norm is a pipelined restoring divider, one quotient bit per stage
// reset: arst_n clears all valid bits and loads the identity quaternion
module quaternion_vector_rotate_core
	import qvr_pkg::*;
#(
	parameter int QUAT_WIDTH = 16,
	parameter int VEC_WIDTH  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [1:0]                             cfg_idx,
	input  logic [QUAT_WIDTH-1:0]                  cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// vec_x, vec_y, vec_z
	input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]       s_tdata,
	// unrotate
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// res_x, res_y, res_z
	output logic [((3*VEC_WIDTH+7)/8)*8-1:0]       m_tdata,
	// zero_norm, clipped
	output logic [1:0]                             m_tuser
);
	localparam int MW  = 2 * QUAT_WIDTH + 2;
	localparam int PW  = 2 * QUAT_WIDTH + VEC_WIDTH + 4;
	localparam int DL  = VEC_WIDTH + 2;
	localparam int TDW = ((3 * VEC_WIDTH + 7) / 8) * 8;

	logic [QUAT_WIDTH-1:0]        rot_q [4];
	logic                         en;
	logic signed [VEC_WIDTH-1:0]  vec_s1 [3];
	logic signed [VEC_WIDTH-1:0]  vec_s2 [3];
	logic signed [MW-1:0]         mat_s2 [9];
	logic [2*QUAT_WIDTH:0]        nrm_s2, nrm_s3, nrm_s4;
	qvr_ctl_t                     ctl_s2, ctl_s3, ctl_s4;
	qvr_ctl_t                     ctl_d [DL];
	logic signed [PW-1:0]         prod_s3 [9];
	logic signed [PW-1:0]         num_s4 [3];
	logic [VEC_WIDTH-1:0]         res [3];
	logic                         clip [3];
	qvr_ctl_t                     ctl_o;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[REG_W] <= QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);
			rot_q[REG_X] <= '0;
			rot_q[REG_Y] <= '0;
			rot_q[REG_Z] <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_W:   rot_q[REG_W] <= cfg_data;
				REG_X:   rot_q[REG_X] <= cfg_data;
				REG_Y:   rot_q[REG_Y] <= cfg_data;
				REG_Z:   rot_q[REG_Z] <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances unless the output word is held
	assign ctl_o    = ctl_d[DL-1];
	assign en       = !ctl_o.vld || m_tready;
	assign s_tready = en;

	qvr_coef #(.QUAT_WIDTH(QUAT_WIDTH)) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.unrotate (s_tuser),
		.rot_w    (signed'(rot_q[REG_W])),
		.rot_x    (signed'(rot_q[REG_X])),
		.rot_y    (signed'(rot_q[REG_Y])),
		.rot_z    (signed'(rot_q[REG_Z])),
		.mat_s2   (mat_s2),
		.nrm_s2   (nrm_s2),
		.ctl_s2   (ctl_s2)
	);

	// vector rides along with the coefficient stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vec_s1[i] <= signed'(s_tdata[i*VEC_WIDTH +: VEC_WIDTH]);
				vec_s2[i] <= vec_s1[i];
			end
		end
	end

	// stage 3: matrix times vector, stage 4: row sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s3[3*r+c] <= PW'(PW'(mat_s2[3*r+c]) * PW'(vec_s2[c]));
				end
				num_s4[r] <= prod_s3[3*r] + prod_s3[3*r+1] + prod_s3[3*r+2];
			end
			nrm_s3 <= nrm_s2;
			nrm_s4 <= nrm_s3;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_div
		qvr_div #(.QUAT_WIDTH(QUAT_WIDTH), .VEC_WIDTH(VEC_WIDTH)) u_div (
			.clk    (clk),
			.en     (en),
			.num    (num_s4[r]),
			.nrm    (nrm_s4),
			.res_q  (res[r]),
			.clip_q (clip[r])
		);
	end

	// control delay line matched to the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			for (int i = 0; i < DL; i++) begin
				ctl_d[i] <= '0;
			end
		end else if (en) begin
			ctl_s3   <= ctl_s2;
			ctl_s4   <= ctl_s3;
			ctl_d[0] <= ctl_s4;
			for (int i = 1; i < DL; i++) begin
				ctl_d[i] <= ctl_d[i-1];
			end
		end
	end

	// output word, forced to zero on a zero quaternion
	assign m_tvalid = ctl_o.vld;
	assign m_tdata  = ctl_o.znorm ? '0 : TDW'({res[2], res[1], res[0]});
	assign m_tuser  = {!ctl_o.znorm && (clip[0] || clip[1] || clip[2]), ctl_o.znorm};

endmodule

// ----- design/qvr_coef.sv -----
`timescale 1ns / 1ps
module qvr_coef
	import qvr_pkg::*;
#(
	parameter int QUAT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic                             unrotate,
	input  logic signed [QUAT_WIDTH-1:0]     rot_w,
	input  logic signed [QUAT_WIDTH-1:0]     rot_x,
	input  logic signed [QUAT_WIDTH-1:0]     rot_y,
	input  logic signed [QUAT_WIDTH-1:0]     rot_z,
	output logic signed [2*QUAT_WIDTH+1:0]   mat_s2 [9],
	output logic        [2*QUAT_WIDTH:0]     nrm_s2,
	output qvr_ctl_t                         ctl_s2
);
	localparam int MW = 2 * QUAT_WIDTH + 2;

	logic signed [MW-1:0] we, ae, be, ce;
	logic signed [MW-1:0] ww_s1, aa_s1, bb_s1, cc_s1, ab_s1, ac_s1, bc_s1;
	logic signed [MW-1:0] wa_s1, wb_s1, wc_s1;
	logic                 vld_s1;
	logic signed [MW-1:0] nsum;

	assign we = MW'(rot_w);
	assign ae = MW'(rot_x);
	assign be = MW'(rot_y);
	assign ce = MW'(rot_z);

	// stage 1: pairwise products, conjugate flips the cross terms with w
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= MW'(we * we);
			aa_s1 <= MW'(ae * ae);
			bb_s1 <= MW'(be * be);
			cc_s1 <= MW'(ce * ce);
			ab_s1 <= MW'(ae * be);
			ac_s1 <= MW'(ae * ce);
			bc_s1 <= MW'(be * ce);
			wa_s1 <= unrotate ? MW'(-(we * ae)) : MW'(we * ae);
			wb_s1 <= unrotate ? MW'(-(we * be)) : MW'(we * be);
			wc_s1 <= unrotate ? MW'(-(we * ce)) : MW'(we * ce);
		end
	end

	assign nsum = ww_s1 + aa_s1 + bb_s1 + cc_s1;

	// stage 2: rotation matrix entries and squared norm
	always_ff @(posedge clk) begin
		if (en) begin
			mat_s2[0] <= ww_s1 + aa_s1 - bb_s1 - cc_s1;
			mat_s2[1] <= MW'((ab_s1 - wc_s1) <<< 1);
			mat_s2[2] <= MW'((ac_s1 + wb_s1) <<< 1);
			mat_s2[3] <= MW'((ab_s1 + wc_s1) <<< 1);
			mat_s2[4] <= ww_s1 - aa_s1 + bb_s1 - cc_s1;
			mat_s2[5] <= MW'((bc_s1 - wa_s1) <<< 1);
			mat_s2[6] <= MW'((ac_s1 - wb_s1) <<< 1);
			mat_s2[7] <= MW'((bc_s1 + wa_s1) <<< 1);
			mat_s2[8] <= ww_s1 - aa_s1 - bb_s1 + cc_s1;
			nrm_s2    <= nsum[MW-2:0];
		end
	end

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ctl_s2 <= '0;
		end else if (en) begin
			vld_s1       <= in_vld;
			ctl_s2.vld   <= vld_s1;
			ctl_s2.znorm <= (nsum == '0);
		end
	end

endmodule

// ----- design/qvr_div.sv -----
`timescale 1ns / 1ps
module qvr_div
	import qvr_pkg::*;
#(
	parameter int QUAT_WIDTH = 16,
	parameter int VEC_WIDTH  = 32
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [2*QUAT_WIDTH+VEC_WIDTH+3:0] num,
	input  logic        [2*QUAT_WIDTH:0]          nrm,
	output logic        [VEC_WIDTH-1:0]           res_q,
	output logic                                  clip_q
);
	localparam int PW = 2 * QUAT_WIDTH + VEC_WIDTH + 4;
	localparam int NW = PW + 1;

	logic [NW-1:0]        rem_s [VEC_WIDTH+1];
	logic [NW-1:0]        den_s [VEC_WIDTH+1];
	logic [VEC_WIDTH-1:0] quo_s [VEC_WIDTH+1];
	logic                 neg_s [VEC_WIDTH+1];
	logic                 ovf_s [VEC_WIDTH+1];
	logic [PW-1:0]        mag;
	logic [VEC_WIDTH-1:0] lim, qf;
	logic                 over;

	assign mag = num[PW-1] ? PW'(-num) : PW'(num);

	// prep: round to nearest as floor((2|n| + d) / 2d)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {mag, 1'b0} + NW'(nrm);
			den_s[0] <= NW'({nrm, 1'b0});
			quo_s[0] <= '0;
			neg_s[0] <= num[PW-1];
			ovf_s[0] <= 1'b0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < VEC_WIDTH; k++) begin : g_step
		logic [NW-1:0] dsh;
		logic          ge;
		assign dsh = den_s[k] << (VEC_WIDTH - 1 - k);
		assign ge  = rem_s[k] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				quo_s[k+1] <= quo_s[k] | (ge ? VEC_WIDTH'(1) << (VEC_WIDTH - 1 - k) : '0);
				if (k == 0) begin
					ovf_s[k+1] <= rem_s[k] >= (den_s[k] << VEC_WIDTH);
				end else begin
					ovf_s[k+1] <= ovf_s[k];
				end
			end
		end
	end

	// saturate to the signed range
	assign qf   = quo_s[VEC_WIDTH];
	assign lim  = neg_s[VEC_WIDTH] ? {1'b1, {(VEC_WIDTH-1){1'b0}}}
	                               : {1'b0, {(VEC_WIDTH-1){1'b1}}};
	assign over = ovf_s[VEC_WIDTH] || (qf > lim);

	always_ff @(posedge clk) begin
		if (en) begin
			clip_q <= over;
			if (over) begin
				res_q <= lim;
			end else begin
				res_q <= neg_s[VEC_WIDTH] ? VEC_WIDTH'(-qf) : qf;
			end
		end
	end

endmodule

// ----- tb/sv/quaternion_vector_rotate_core_test.sv -----
`timescale 1ns / 1ps
module quaternion_vector_rotate_core_test;
	import qvr_pkg::*;

	localparam int QW = 16;
	localparam int VW = 32;
	localparam int DW = ((3*VW+7)/8)*8;
	localparam int LATENCY = VW + 6;
	localparam int NUM_RANDOM = 1850;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [VW-1:0] x, y, z;
		logic zn, clip;
	} rot_word_t;

	// expected rotated vectors, oldest first
	class rotation_board;
		rot_word_t pending[$];
		logic signed [QW-1:0] quat[4];
		int errors;

		function new();
			quat[REG_W] = 16'sd16384;
			quat[REG_X] = 0;
			quat[REG_Y] = 0;
			quat[REG_Z] = 0;
			errors = 0;
		endfunction

		// rounded quotient, ties away from zero, saturated
		function automatic logic [VW-1:0] round_sat(logic signed [127:0] num,
				logic signed [127:0] nrm, ref bit clip);
			logic signed [127:0] mag, q, lim;
			logic neg;
			neg = num < 0;
			mag = neg ? -num : num;
			q = (2*mag + nrm) / (2*nrm);
			lim = neg ? (128'sd1 <<< (VW-1)) : ((128'sd1 <<< (VW-1)) - 1);
			if (q > lim) begin
				clip = 1;
				q = lim;
			end
			return neg ? VW'(-q) : VW'(q);
		endfunction

		function void note_vector(logic [DW-1:0] d, logic unrot);
			logic signed [127:0] w, a, b, c, x, y, z, nrm, rx, ry, rz;
			rot_word_t e;
			bit clip;
			w = quat[REG_W];
			a = quat[REG_X];
			b = quat[REG_Y];
			c = quat[REG_Z];
			x = $signed(d[VW-1:0]);
			y = $signed(d[2*VW-1:VW]);
			z = $signed(d[3*VW-1:2*VW]);
			clip = 0;
			if (unrot) begin
				a = -a;
				b = -b;
				c = -c;
			end
			nrm = w*w + a*a + b*b + c*c;
			if (nrm == 0) begin
				e.x = 0;
				e.y = 0;
				e.z = 0;
				e.zn = 1;
				e.clip = 0;
			end else begin
				rx = (w*w + a*a - b*b - c*c)*x + 2*(a*b - w*c)*y + 2*(a*c + w*b)*z;
				ry = 2*(a*b + w*c)*x + (w*w - a*a + b*b - c*c)*y + 2*(b*c - w*a)*z;
				rz = 2*(a*c - w*b)*x + 2*(b*c + w*a)*y + (w*w - a*a - b*b + c*c)*z;
				e.x = round_sat(rx, nrm, clip);
				e.y = round_sat(ry, nrm, clip);
				e.z = round_sat(rz, nrm, clip);
				e.zn = 0;
				e.clip = clip;
			end
			pending.push_back(e);
		endfunction

		function void check_vector(logic [DW-1:0] d, logic [1:0] u);
			rot_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h %b", $time, d, u);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[VW-1:0] !== e.x) begin
				$display("%0t: res_x expected %h actual %h", $time, e.x, d[VW-1:0]);
				errors++;
			end
			if (d[2*VW-1:VW] !== e.y) begin
				$display("%0t: res_y expected %h actual %h", $time, e.y, d[2*VW-1:VW]);
				errors++;
			end
			if (d[3*VW-1:2*VW] !== e.z) begin
				$display("%0t: res_z expected %h actual %h", $time, e.z, d[3*VW-1:2*VW]);
				errors++;
			end
			if (u[0] !== e.zn) begin
				$display("%0t: zero_norm expected %b actual %b", $time, e.zn, u[0]);
				errors++;
			end
			if (u[1] !== e.clip) begin
				$display("%0t: clipped expected %b actual %b", $time, e.clip, u[1]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we;
	logic [1:0] cfg_idx;
	logic [QW-1:0] cfg_data;
	logic s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
	// vec_x, vec_y, vec_z
	logic [DW-1:0] s_tdata;
	// res_x, res_y, res_z
	logic [DW-1:0] m_tdata;
	// zero_norm, clipped
	logic [1:0] m_tuser;

	rotation_board board;
	longint cycles;
	bit sink_busy;

	quaternion_vector_rotate_core #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) DUT (.*);

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// gap length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side with random stalls
	initial begin
		m_tready = 0;
		sink_busy = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_vector(m_tdata, m_tuser);
			if (sink_busy)
				m_tready <= ($urandom_range(0, 9) != 0);
			else
				m_tready <= (gap_len() == 0);
		end
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("quaternion_vector_rotate_core_test failed");
				$finish;
			end
		end
	end

	// write enable stays high across a burst; the caller drops it
	task automatic write_reg(reg_idx_t idx, logic [QW-1:0] v);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		board.quat[idx] = v;
	endtask

	task automatic load_quat(logic [QW-1:0] w, logic [QW-1:0] x, logic [QW-1:0] y,
			logic [QW-1:0] z);
		write_reg(REG_W, w);
		write_reg(REG_X, x);
		write_reg(REG_Y, y);
		write_reg(REG_Z, z);
		cfg_we <= 0;
	endtask

	// send one vector word; valid stays high across back-to-back words
	task automatic send_vector(logic [VW-1:0] x, logic [VW-1:0] y, logic [VW-1:0] z,
			logic unrot);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= DW'({z, y, x});
		s_tuser <= unrot;
		do @(posedge clk); while (!s_tready);
		board.note_vector(DW'({z, y, x}), unrot);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [VW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 1 << 20))) :
				-32'(int'($urandom_range(0, 1 << 20)));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [QW-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 0;
			default: return 16'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int n;
		board = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_W;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity quaternion after reset, field extremes
		send_vector(32'h7fff_ffff, 32'h8000_0000, 0, 0);
		send_vector(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1);
		send_vector(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 0);
		drain();
		// 90 degrees about z, with and without unrotate
		load_quat(16'd11585, 0, 0, 16'd11585);
		send_vector(32'h0001_0000, 0, 0, 0);
		send_vector(32'h0001_0000, 0, 0, 1);
		send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
		drain();
		// zero quaternion
		load_quat(0, 0, 0, 0);
		send_vector(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_vector(32'h0000_0001, 0, 0, 1);
		drain();
		// extreme components, non-unit norm, ties in rounding
		load_quat(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_vector(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 0);
		send_vector(32'h0000_0001, 32'hffff_ffff, 32'h0000_0003, 1);
		drain();
		load_quat(16'd2, 16'd1, 0, 0);
		send_vector(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 0);
		send_vector(32'h0000_0003, 32'hffff_fffd, 32'h0000_0005, 1);
		drain();

		// random phases with a new quaternion each time
		n = 0;
		while (n < NUM_RANDOM) begin
			if ($urandom_range(0, 7) == 0)
				load_quat(0, 0, 0, 0);
			else
				load_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
			sink_busy = 1'($urandom_range(0, 1));
			repeat ($urandom_range(20, 200)) begin
				if (n < NUM_RANDOM) begin
					send_vector(rand_coord(), rand_coord(), rand_coord(),
						1'($urandom_range(0, 1)));
					n++;
				end
			end
			drain();
		end

		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("quaternion_vector_rotate_core_test passed");
		else
			$display("quaternion_vector_rotate_core_test failed");
		$finish;
	end

endmodule
